// ----- hdl/keypad_event_generator_assert.svh -----
// assertion macros for the keypad event generator
`ifndef KEYPAD_EVENT_GENERATOR_ASSERT_SVH
`define KEYPAD_EVENT_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define KEV_ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("keypad event generator: assertion failed");
`define KEV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad event generator: assertion failed");
`else
`define KEV_ASSERT_HOLDS(label, clk, rst, prop)
`define KEV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/kev_pkg.sv -----
package kev_pkg;

  localparam int ROWS       = 12;
  localparam int COLS       = 4;
  localparam int NPOS       = ROWS * COLS;
  localparam int POS_W      = $clog2(NPOS);
  localparam int TIME_W     = 32;
  localparam int WIN_W      = 16;
  localparam int CODE_W     = 9;
  localparam int MAX_EVENTS = 4;
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
  localparam int SLOT_W     = $clog2(MAX_EVENTS);
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE = 1'b1;

  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'd14;
  localparam logic [CODE_W-1:0] CODE_LEFTSHIFT = 9'd42;
  localparam logic [WIN_W-1:0]  WINDOW_RESET   = 16'd250;

  typedef enum logic [1:0] {KEY_NONE, KEY_CODE, KEY_MODE} key_kind_t;
  typedef enum logic [1:0] {ALT_NONE, ALT_CODE, ALT_REBOOT} alt_kind_t;
  typedef enum logic [1:0] {MODE_OFF, MODE_ONCE, MODE_LOCKED} mode_t;

  typedef struct packed {
    logic [CODE_W-1:0] key;
    key_kind_t         key_kind;
    logic [CODE_W-1:0] alt;
    alt_kind_t         alt_kind;
    logic              shift;
  } keymap_t;

  // per-key table entry
  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              value;
    logic              reboot;
  } event_t;

  typedef struct packed {
    event_t [MAX_EVENTS-1:0] ev;
    logic [CNT_W-1:0]        count;
  } bundle_t;

  function automatic keymap_t km_code(input logic [CODE_W-1:0] k,
                                      input logic [CODE_W-1:0] a, input logic s);
    km_code = '{key: k, key_kind: KEY_CODE, alt: a, alt_kind: ALT_CODE, shift: s};
  endfunction

  function automatic keymap_t km_plain(input logic [CODE_W-1:0] k);
    km_plain = '{key: k, key_kind: KEY_CODE, alt: '0, alt_kind: ALT_NONE, shift: 1'b0};
  endfunction

  function automatic keymap_t km_reboot(input logic [CODE_W-1:0] k);
    km_reboot = '{key: k, key_kind: KEY_CODE, alt: '0, alt_kind: ALT_REBOOT, shift: 1'b0};
  endfunction

  function automatic keymap_t km_special(input key_kind_t kk);
    km_special = '{key: '0, key_kind: kk, alt: '0, alt_kind: ALT_NONE, shift: 1'b0};
  endfunction

  function automatic event_t mk_event(input logic [CODE_W-1:0] code, input logic value,
                                      input logic reboot);
    mk_event = '{code: code, value: value, reboot: reboot};
  endfunction

  function automatic keymap_t keymap_lookup(input logic [POS_W-1:0] pos);
    keymap_t e;
    e = km_special(KEY_NONE);
    unique case (pos)
      0:  e = km_code(9'd59, 9'd63, 1'b0);
      1:  e = km_code(9'd60, 9'd64, 1'b0);
      2:  e = km_code(9'd61, 9'd65, 1'b0);
      3:  e = km_code(9'd62, 9'd66, 1'b0);
      4:  e = km_code(9'd45, 9'd10, 1'b1);
      5:  e = km_code(9'd108, 9'd109, 1'b0);
      6:  e = km_code(9'd29, 9'd67, 1'b0);
      7:  e = km_plain(9'd28);
      8:  e = km_reboot(9'd116);
      12: e = km_code(9'd15, 9'd43, 1'b1);
      13: e = km_code(9'd32, 9'd78, 1'b0);
      14: e = km_code(9'd35, 9'd12, 1'b1);
      15: e = km_code(9'd52, 9'd39, 1'b1);
      16: e = km_code(9'd30, 9'd13, 1'b0);
      17: e = km_code(9'd46, 9'd11, 1'b1);
      18: e = km_code(9'd44, 9'd7, 1'b0);
      19: e = km_code(9'd38, 9'd51, 1'b1);
      20: e = km_code(9'd16, 9'd2, 1'b0);
      21: e = km_code(9'd33, 9'd74, 1'b0);
      22: e = km_code(9'd49, 9'd51, 1'b0);
      23: e = km_code(9'd24, 9'd10, 1'b0);
      24: e = km_code(9'd42, 9'd8, 1'b1);
      25: e = km_code(9'd19, 9'd5, 1'b0);
      26: e = km_code(9'd36, 9'd53, 1'b0);
      27: e = km_code(9'd56, 9'd68, 1'b0);
      28: e = km_code(9'd21, 9'd5, 1'b1);
      29: e = km_code(9'd57, 9'd1, 1'b0);
      30: e = km_code(9'd22, 9'd8, 1'b0);
      31: e = km_code(9'd28, 9'd39, 1'b0);
      32: e = km_code(9'd31, 9'd40, 1'b1);
      33: e = km_code(9'd47, 9'd4, 1'b1);
      34: e = km_code(9'd50, 9'd53, 1'b1);
      35: e = km_code(9'd14, 9'd52, 1'b1);
      36: e = km_code(9'd17, 9'd3, 1'b0);
      37: e = km_code(9'd34, 9'd55, 1'b0);
      38: e = km_code(9'd37, 9'd40, 1'b0);
      39: e = km_code(9'd25, 9'd11, 1'b0);
      40: e = km_code(9'd18, 9'd4, 1'b0);
      41: e = km_code(9'd20, 9'd6, 1'b0);
      42: e = km_code(9'd23, 9'd9, 1'b0);
      43: e = km_code(9'd48, 9'd2, 1'b1);
      44: e = km_code(9'd103, 9'd104, 1'b0);
      45: e = km_code(9'd105, 9'd102, 1'b0);
      46: e = km_code(9'd106, 9'd107, 1'b0);
      47: e = km_special(KEY_MODE);
      default: e = km_special(KEY_NONE);
    endcase
    return e;
  endfunction

endpackage

// ----- hdl/kev_ram.sv -----
module kev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/kev_state.sv -----
module kev_state (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [kev_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [kev_pkg::WIN_W-1:0]     cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [3:0]                    row_index,
  input  logic [1:0]                    col_index,
  input  logic                          contact_closed,
  input  logic [kev_pkg::TIME_W-1:0]    now_ms,
  input  logic                          out_free,
  output logic                          push,
  output kev_pkg::bundle_t              bundle
);
  import kev_pkg::*;

  logic [WIN_W-1:0]  window;
  logic              dc_enable;
  mode_t             mode;
  mode_t             mode_next;
  logic [NPOS-1:0]   ent_valid;

  logic              s1_valid;
  logic              s1_inrange;
  logic [POS_W-1:0]  s1_pos;
  logic              s1_closed;
  logic [TIME_W-1:0] s1_now;

  logic              fwd_hit;
  entry_t            fwd_data;

  logic              in_accept;
  logic              in_range;
  logic [POS_W-1:0]  in_pos;
  logic              s1_fire;
  logic              upd;
  logic              ram_we;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  entry_t            ent;
  keymap_t           km;
  logic [TIME_W-1:0] gap;
  logic [CNT_W-1:0]  n;
  bundle_t           bnd;

  assign in_range     = (int'(row_index) < ROWS) && (int'(col_index) < COLS);
  assign in_pos       = in_range ? POS_W'(int'(row_index) * COLS + int'(col_index)) : '0;
  assign s1_fire      = s1_valid && ((n == '0) || out_free);
  assign sample_stall = s1_valid && !s1_fire;
  assign in_accept    = sample_valid && !sample_stall;
  assign ram_we       = upd && s1_fire;
  assign push         = s1_fire && (n != '0);
  assign bundle       = bnd;

  kev_ram #(.WIDTH($bits(entry_t)), .DEPTH(NPOS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_pos),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (in_pos),
    .rdata (ram_rdata)
  );

  // a write landing in the cycle of the next read is forwarded
  assign ent = fwd_hit ? fwd_data : (ent_valid[s1_pos] ? ram_rdata : '0);
  assign km  = keymap_lookup(s1_pos);
  assign gap = s1_now - ent.stamp;

  always_comb begin
    bnd       = '0;
    n         = '0;
    mode_next = mode;
    upd       = 1'b0;
    ram_wdata = ent;
    if (s1_valid && s1_inrange) begin
      if (s1_closed && !ent.pressed) begin
        upd       = 1'b1;
        ram_wdata = '{pressed: 1'b1, stamp: s1_now};
        if (dc_enable && (gap < TIME_W'(window))) begin
          if (km.alt_kind == ALT_CODE) begin
            bnd.ev[SLOT_W'(n)] = mk_event(CODE_BACKSPACE, 1'b1, 1'b0);
            n = n + 1'b1;
            bnd.ev[SLOT_W'(n)] = mk_event(CODE_BACKSPACE, 1'b0, 1'b0);
            n = n + 1'b1;
            if (km.shift) begin
              bnd.ev[SLOT_W'(n)] = mk_event(CODE_LEFTSHIFT, 1'b1, 1'b0);
              n = n + 1'b1;
            end
            bnd.ev[SLOT_W'(n)] = mk_event(km.alt, 1'b1, 1'b0);
            n = n + 1'b1;
            mode_next = MODE_OFF;
          end
        end else if (km.key_kind == KEY_MODE) begin
          case (mode)
            MODE_OFF:  mode_next = MODE_ONCE;
            MODE_ONCE: mode_next = MODE_LOCKED;
            default:   mode_next = MODE_OFF;
          endcase
        end else if (mode != MODE_OFF) begin
          if (km.alt_kind == ALT_REBOOT) begin
            bnd.ev[SLOT_W'(n)] = mk_event('0, 1'b0, 1'b1);
            n = n + 1'b1;
          end else if (km.alt_kind == ALT_CODE) begin
            if (km.shift) begin
              bnd.ev[SLOT_W'(n)] = mk_event(CODE_LEFTSHIFT, 1'b1, 1'b0);
              n = n + 1'b1;
            end
            bnd.ev[SLOT_W'(n)] = mk_event(km.alt, 1'b1, 1'b0);
            n = n + 1'b1;
          end
          if (mode != MODE_LOCKED) begin
            mode_next = MODE_OFF;
          end
        end else if (km.key_kind == KEY_CODE) begin
          bnd.ev[SLOT_W'(n)] = mk_event(km.key, 1'b1, 1'b0);
          n = n + 1'b1;
        end
      end else if (!s1_closed && ent.pressed) begin
        upd       = 1'b1;
        ram_wdata = '{pressed: 1'b0, stamp: ent.stamp};
        if (km.key_kind == KEY_CODE) begin
          bnd.ev[SLOT_W'(n)] = mk_event(km.key, 1'b0, 1'b0);
          n = n + 1'b1;
          if (km.alt_kind == ALT_CODE) begin
            if (km.shift) begin
              bnd.ev[SLOT_W'(n)] = mk_event(CODE_LEFTSHIFT, 1'b0, 1'b0);
              n = n + 1'b1;
            end
            bnd.ev[SLOT_W'(n)] = mk_event(km.alt, 1'b0, 1'b0);
            n = n + 1'b1;
          end
        end
      end
    end
    bnd.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= WINDOW_RESET;
      dc_enable <= 1'b1;
      mode      <= MODE_OFF;
      ent_valid <= '0;
      s1_valid  <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WINDOW: window    <= cfg_data;
          REG_ENABLE: dc_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (s1_fire) begin
        mode <= mode_next;
      end
      if (ram_we) begin
        ent_valid[s1_pos] <= 1'b1;
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= ram_we && (s1_pos == in_pos);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_inrange <= in_range;
      s1_pos     <= in_pos;
      s1_closed  <= contact_closed;
      s1_now     <= now_ms;
      fwd_data   <= ram_wdata;
    end
  end

endmodule

// ----- hdl/kev_out_queue.sv -----
module kev_out_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  kev_pkg::bundle_t            bundle,
  output logic                        out_free,
  output logic                        event_valid,
  input  logic                        event_stall,
  output logic [kev_pkg::CODE_W-1:0]  event_code,
  output logic                        event_value,
  output logic                        sync_after,
  output logic                        reboot_request,
  output logic                        last_event
);
  import kev_pkg::*;

  logic              ob_valid;
  bundle_t           ob_bundle;
  logic [SLOT_W-1:0] ob_slot;
  logic              fire;
  logic              last;
  event_t            ev;

  assign fire     = ob_valid && !event_stall;
  assign last     = (CNT_W'(ob_slot) == (ob_bundle.count - CNT_W'(1)));
  assign out_free = !ob_valid || (fire && last);
  assign ev       = ob_bundle.ev[ob_slot];

  assign event_valid    = ob_valid;
  assign event_code     = ev.code;
  assign event_value    = ev.value;
  assign reboot_request = ev.reboot;
  // the final beat of a sample carries the sync marker
  assign sync_after     = last;
  assign last_event     = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      ob_slot  <= '0;
    end else if (push) begin
      ob_valid <= 1'b1;
      ob_slot  <= '0;
    end else if (fire && last) begin
      ob_valid <= 1'b0;
    end else if (fire) begin
      ob_slot <= ob_slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ob_bundle <= bundle;
    end
  end

endmodule

// ----- hdl/keypad_event_generator.sv -----
// a sample is registered in stage s1, then its events in the output buffer
// throughput: one sample per cycle while each sample gives at most one event and the
//   event port takes a beat each cycle; a sample gives up to four events and stalls the next
// the per-key table is one memory with one read and one write port
// reset (synchronous, rst high): window 250 ms, double click on, mode off, all keys up,
//   per-entry valid bits cleared at once, no clearing pass
`include "keypad_event_generator_assert.svh"

module keypad_event_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [kev_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [kev_pkg::WIN_W-1:0]     cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [3:0]                    row_index,
  input  logic [1:0]                    col_index,
  input  logic                          contact_closed,
  input  logic [kev_pkg::TIME_W-1:0]    now_ms,
  output logic                          event_valid,
  input  logic                          event_stall,
  output logic [kev_pkg::CODE_W-1:0]    event_code,
  output logic                          event_value,
  output logic                          sync_after,
  output logic                          reboot_request,
  output logic                          last_event
);
  import kev_pkg::*;

  logic    push;
  logic    out_free;
  bundle_t bundle;

  kev_state u_state (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .row_index      (row_index),
    .col_index      (col_index),
    .contact_closed (contact_closed),
    .now_ms         (now_ms),
    .out_free       (out_free),
    .push           (push),
    .bundle         (bundle)
  );

  kev_out_queue u_out (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .bundle         (bundle),
    .out_free       (out_free),
    .event_valid    (event_valid),
    .event_stall    (event_stall),
    .event_code     (event_code),
    .event_value    (event_value),
    .sync_after     (sync_after),
    .reboot_request (reboot_request),
    .last_event     (last_event)
  );

  `KEV_ASSERT_HOLDS(a_push_free, clk, rst, !push || out_free)
  `KEV_ASSERT_NEXT(a_push_shows, clk, rst, push, event_valid)
  `KEV_ASSERT_HOLDS(a_reboot_alone, clk, rst,
    !(event_valid && reboot_request) || ((event_code == '0) && !event_value && last_event))
  `KEV_ASSERT_HOLDS(a_last_sync, clk, rst, !event_valid || (last_event == sync_after))

endmodule
